// ----- sv/sts_pkg.sv -----
// Shared constants and codes of the SRAM test sequencer.
package sts_pkg;

   // Widths of bytes, masks, codes and registers
   localparam int DATA_W   = 8;
   localparam int AMASK_W  = 16;
   localparam int CMD_W    = 2;
   localparam int PART_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 11;

   // Command codes on the result channel
   localparam logic [CMD_W-1:0] CMD_IDLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DONE  = 2'd3;

   // Test part codes reported with each operation
   localparam logic [PART_W-1:0] TP_DATA   = 3'd0;
   localparam logic [PART_W-1:0] TP_ADDR   = 3'd1;
   localparam logic [PART_W-1:0] TP_FILL   = 3'd2;
   localparam logic [PART_W-1:0] TP_CHECK1 = 3'd3;
   localparam logic [PART_W-1:0] TP_CHECK2 = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE = 2'd2;

   // Register reset values
   localparam logic [CSR_W-1:0]  TOP_RESET   = 11'h7FF;
   localparam logic [DATA_W-1:0] BG_RESET    = 8'hAA;
   localparam logic [DATA_W-1:0] PROBE_RESET = 8'h55;

   // Address-line mask entry while address zero is probed
   localparam logic [AMASK_W-1:0] ZERO_LIGHTS = 16'hF000;

endpackage

// ----- sv/sram_test_sequencer.sv -----
// Top level of the SRAM test sequencer: input register, step core, result register, CSRs.
//
//  channel   | ports                         | role
//  ----------+-------------------------------+-------------------------------------
//  request   | req_valid/req_ready, req_*    | step command and returned read byte
//  response  | rsp_valid/rsp_ready, rsp_*    | next memory operation and check result
//  csr       | csr_we, csr_index, csr_wdata  | top address, background, probe pattern
//
// One transfer in gives one transfer out; a new request is taken every cycle
// while no stalled response holds the request register. The request is registered,
// then the step logic loads the response register.
// Reset clears the test state and loads the register defaults.
// A stalled response holds; the request register takes one more transfer, then
// req_ready stays low until the response is taken.
module sram_test_sequencer #(
   parameter int ADDR_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [sts_pkg::DATA_W-1:0]        req_read_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sts_pkg::CMD_W-1:0]         rsp_command,
   output logic [ADDR_BITS-1:0]              rsp_mem_address,
   output logic [sts_pkg::DATA_W-1:0]        rsp_write_value,
   output logic                              rsp_mismatch,
   output logic [sts_pkg::DATA_W-1:0]        rsp_golden_value,
   output logic [sts_pkg::DATA_W-1:0]        rsp_observed_value,
   output logic [ADDR_BITS-1:0]              rsp_failed_address,
   output logic [sts_pkg::PART_W-1:0]        rsp_test_part,
   output logic [sts_pkg::DATA_W-1:0]        rsp_data_bus_fails,
   output logic [sts_pkg::AMASK_W-1:0]       rsp_address_bus_fails,
   input  logic                              csr_we,
   input  logic [sts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sts_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int TW = (ADDR_BITS > sts_pkg::CSR_W) ? ADDR_BITS : sts_pkg::CSR_W;
   localparam logic [TW-1:0] TOP_RESET_W = TW'(sts_pkg::TOP_RESET);

   logic [ADDR_BITS-1:0]          top_ff, top_in;
   logic [sts_pkg::DATA_W-1:0]    bg_ff, bg_in;
   logic [sts_pkg::DATA_W-1:0]    probe_ff, probe_in;
   logic [TW-1:0]                 wdata_w;

   logic                          in_v_ff, in_v_in;
   logic                          in_mode_ff, in_mode_in;
   logic [sts_pkg::DATA_W-1:0]    in_rd_ff, in_rd_in;
   logic                          out_v_ff, out_v_in;
   logic                          advance;
   logic                          req_fire;

   logic [sts_pkg::CMD_W-1:0]     res_command;
   logic [ADDR_BITS-1:0]          res_mem_address;
   logic [sts_pkg::DATA_W-1:0]    res_write_value;
   logic                          res_mismatch;
   logic [sts_pkg::DATA_W-1:0]    res_golden_value;
   logic [sts_pkg::DATA_W-1:0]    res_observed_value;
   logic [ADDR_BITS-1:0]          res_failed_address;
   logic [sts_pkg::PART_W-1:0]    res_test_part;
   logic [sts_pkg::DATA_W-1:0]    res_data_bus_fails;
   logic [sts_pkg::AMASK_W-1:0]   res_address_bus_fails;

   logic [sts_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0]          maddr_ff, maddr_in;
   logic [sts_pkg::DATA_W-1:0]    wval_ff, wval_in;
   logic                          mis_ff, mis_in;
   logic [sts_pkg::DATA_W-1:0]    exp_ff, exp_in;
   logic [sts_pkg::DATA_W-1:0]    obs_ff, obs_in;
   logic [ADDR_BITS-1:0]          faddr_ff, faddr_in;
   logic [sts_pkg::PART_W-1:0]    part_ff, part_in;
   logic [sts_pkg::DATA_W-1:0]    dfail_ff, dfail_in;
   logic [sts_pkg::AMASK_W-1:0]   afail_ff, afail_in;

   // Register writes; top address cut to the address width
   assign wdata_w = TW'(csr_wdata);
   always_comb begin
      top_in   = top_ff;
      bg_in    = bg_ff;
      probe_in = probe_ff;
      if (csr_we) begin
         case (csr_index)
            sts_pkg::CSR_TOP:   top_in   = wdata_w[ADDR_BITS-1:0];
            sts_pkg::CSR_BG:    bg_in    = csr_wdata[sts_pkg::DATA_W-1:0];
            sts_pkg::CSR_PROBE: probe_in = csr_wdata[sts_pkg::DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: request register moves on when the response slot is free
   assign advance   = in_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_v_in    = req_fire ? 1'b1 : (advance ? 1'b0 : in_v_ff);
   assign in_mode_in = req_fire ? req_mode : in_mode_ff;
   assign in_rd_in   = req_fire ? req_read_data : in_rd_ff;
   assign out_v_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

   sts_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock                 (clock),
      .reset                 (reset),
      .fire                  (advance),
      .mode                  (in_mode_ff),
      .read_data             (in_rd_ff),
      .top_address           (top_ff),
      .background_pattern    (bg_ff),
      .probe_pattern         (probe_ff),
      .res_command           (res_command),
      .res_mem_address       (res_mem_address),
      .res_write_value       (res_write_value),
      .res_mismatch          (res_mismatch),
      .res_golden_value      (res_golden_value),
      .res_observed_value    (res_observed_value),
      .res_failed_address    (res_failed_address),
      .res_test_part         (res_test_part),
      .res_data_bus_fails    (res_data_bus_fails),
      .res_address_bus_fails (res_address_bus_fails)
   );

   // Response payload loads on each step
   assign cmd_in   = advance ? res_command           : cmd_ff;
   assign maddr_in = advance ? res_mem_address       : maddr_ff;
   assign wval_in  = advance ? res_write_value       : wval_ff;
   assign mis_in   = advance ? res_mismatch          : mis_ff;
   assign exp_in   = advance ? res_golden_value      : exp_ff;
   assign obs_in   = advance ? res_observed_value    : obs_ff;
   assign faddr_in = advance ? res_failed_address    : faddr_ff;
   assign part_in  = advance ? res_test_part         : part_ff;
   assign dfail_in = advance ? res_data_bus_fails    : dfail_ff;
   assign afail_in = advance ? res_address_bus_fails : afail_ff;

   // Control and CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         top_ff   <= TOP_RESET_W[ADDR_BITS-1:0];
         bg_ff    <= sts_pkg::BG_RESET;
         probe_ff <= sts_pkg::PROBE_RESET;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         top_ff   <= top_in;
         bg_ff    <= bg_in;
         probe_ff <= probe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_mode_ff <= in_mode_in;
      in_rd_ff   <= in_rd_in;
      cmd_ff     <= cmd_in;
      maddr_ff   <= maddr_in;
      wval_ff    <= wval_in;
      mis_ff     <= mis_in;
      exp_ff     <= exp_in;
      obs_ff     <= obs_in;
      faddr_ff   <= faddr_in;
      part_ff    <= part_in;
      dfail_ff   <= dfail_in;
      afail_ff   <= afail_in;
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_command           = cmd_ff;
   assign rsp_mem_address       = maddr_ff;
   assign rsp_write_value       = wval_ff;
   assign rsp_mismatch          = mis_ff;
   assign rsp_golden_value      = exp_ff;
   assign rsp_observed_value    = obs_ff;
   assign rsp_failed_address    = faddr_ff;
   assign rsp_test_part         = part_ff;
   assign rsp_data_bus_fails    = dfail_ff;
   assign rsp_address_bus_fails = afail_ff;

endmodule

// ----- sv/sts_core.sv -----
// Test sequencer state and the step logic that issues one memory operation.
module sts_core #(
   parameter int ADDR_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic                              mode,
   input  logic [sts_pkg::DATA_W-1:0]        read_data,
   input  logic [ADDR_BITS-1:0]              top_address,
   input  logic [sts_pkg::DATA_W-1:0]        background_pattern,
   input  logic [sts_pkg::DATA_W-1:0]        probe_pattern,
   output logic [sts_pkg::CMD_W-1:0]         res_command,
   output logic [ADDR_BITS-1:0]              res_mem_address,
   output logic [sts_pkg::DATA_W-1:0]        res_write_value,
   output logic                              res_mismatch,
   output logic [sts_pkg::DATA_W-1:0]        res_golden_value,
   output logic [sts_pkg::DATA_W-1:0]        res_observed_value,
   output logic [ADDR_BITS-1:0]              res_failed_address,
   output logic [sts_pkg::PART_W-1:0]        res_test_part,
   output logic [sts_pkg::DATA_W-1:0]        res_data_bus_fails,
   output logic [sts_pkg::AMASK_W-1:0]       res_address_bus_fails
);

   localparam int CNT_W = (ADDR_BITS > 5) ? ADDR_BITS : 5;
   localparam int PRB_W = $clog2(ADDR_BITS + 1);
   localparam int INC_W = (ADDR_BITS + 1 > sts_pkg::DATA_W) ? ADDR_BITS + 1 : sts_pkg::DATA_W;
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(ADDR_BITS);
   localparam logic [PRB_W-1:0] LAST_PRB = PRB_W'(ADDR_BITS);
   localparam logic [ADDR_BITS-1:0] TOP_BIT = {1'b1, {(ADDR_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      PS_DATA, PS_ADDR, PS_FILL, PS_CHECK1, PS_CHECK2, PS_DONE
   } part_type;

   // Address of a probe position: highest line first, address zero past the last line
   function automatic logic [ADDR_BITS-1:0] pos_addr(input logic [CNT_W-1:0] q);
      pos_addr = TOP_BIT >> q;
   endfunction

   part_type                      part_ff, part_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [PRB_W-1:0]              probe_ff, probe_in;
   logic [1:0]                    sub_ff, sub_in;
   logic                          pend_ff, pend_in;
   logic                          pend_data_ff, pend_data_in;
   logic                          pend_abus_ff, pend_abus_in;
   logic [sts_pkg::DATA_W-1:0]    pend_exp_ff, pend_exp_in;
   logic [ADDR_BITS-1:0]          pend_addr_ff, pend_addr_in;
   logic [sts_pkg::AMASK_W-1:0]   pend_lights_ff, pend_lights_in;
   logic [sts_pkg::DATA_W-1:0]    dmask_ff, dmask_in;
   logic [sts_pkg::AMASK_W-1:0]   amask_ff, amask_in;

   logic [ADDR_BITS-1:0]          lin_addr;
   logic [INC_W-1:0]              inc;
   logic [sts_pkg::DATA_W-1:0]    walk;
   logic                          is_read;
   logic [sts_pkg::DATA_W-1:0]    r_exp;
   logic [sts_pkg::AMASK_W-1:0]   r_lights;
   logic                          at_top;

   assign lin_addr = cnt_ff[ADDR_BITS-1:0];
   assign inc      = INC_W'(lin_addr) + INC_W'(1);
   assign walk     = sts_pkg::DATA_W'(1) << cnt_ff[2:0];
   assign at_top   = (lin_addr >= top_address);

   // Check the returned byte, then issue the next operation
   always_comb begin
      part_in        = part_ff;
      cnt_in         = cnt_ff;
      probe_in       = probe_ff;
      sub_in         = sub_ff;
      pend_in        = pend_ff;
      pend_data_in   = pend_data_ff;
      pend_abus_in   = pend_abus_ff;
      pend_exp_in    = pend_exp_ff;
      pend_addr_in   = pend_addr_ff;
      pend_lights_in = pend_lights_ff;
      dmask_in       = dmask_ff;
      amask_in       = amask_ff;
      res_command        = sts_pkg::CMD_IDLE;
      res_mem_address    = '0;
      res_write_value    = '0;
      res_mismatch       = 1'b0;
      res_golden_value   = '0;
      res_observed_value = '0;
      res_failed_address = '0;
      res_test_part      = sts_pkg::TP_DATA;
      is_read  = 1'b0;
      r_exp    = '0;
      r_lights = '0;
      if (!mode) begin
         // restart: test state back to its reset values
         part_in        = PS_DATA;
         cnt_in         = '0;
         probe_in       = '0;
         sub_in         = '0;
         pend_in        = 1'b0;
         pend_data_in   = 1'b0;
         pend_abus_in   = 1'b0;
         pend_exp_in    = '0;
         pend_addr_in   = '0;
         pend_lights_in = '0;
         dmask_in       = '0;
         amask_in       = '0;
      end else begin
         // check of the read issued last time
         if (pend_ff) begin
            res_golden_value   = pend_exp_ff;
            res_observed_value = read_data;
            res_failed_address = pend_addr_ff;
            if (pend_exp_ff != read_data) begin
               res_mismatch = 1'b1;
               if (pend_data_ff) begin
                  dmask_in = dmask_ff | pend_exp_ff;
               end
               if (pend_abus_ff) begin
                  amask_in = amask_ff | pend_lights_ff;
               end
            end
            pend_in = 1'b0;
         end
         case (part_ff)
            PS_DATA: begin
               res_test_part = sts_pkg::TP_DATA;
               if (sub_ff == 2'd0) begin
                  res_command     = sts_pkg::CMD_WRITE;
                  res_write_value = walk;
                  sub_in          = 2'd1;
                  cnt_in          = CNT_W'(cnt_ff[2:0]);
               end else begin
                  is_read = 1'b1;
                  r_exp   = walk;
                  sub_in  = 2'd0;
                  cnt_in  = CNT_W'(cnt_ff[2:0]) + CNT_W'(1);
                  if (cnt_ff[2:0] == 3'd7) begin
                     part_in  = PS_ADDR;
                     cnt_in   = '0;
                     probe_in = '0;
                  end
               end
            end
            PS_ADDR: begin
               res_test_part = sts_pkg::TP_ADDR;
               if (sub_ff == 2'd0) begin
                  // background at every probe position
                  res_command     = sts_pkg::CMD_WRITE;
                  res_mem_address = pos_addr(cnt_ff);
                  res_write_value = background_pattern;
                  cnt_in          = cnt_ff + CNT_W'(1);
                  if (cnt_ff == LAST_POS) begin
                     cnt_in = '0;
                     sub_in = 2'd1;
                  end
               end else if (sub_ff == 2'd1) begin
                  res_command     = sts_pkg::CMD_WRITE;
                  res_mem_address = pos_addr(CNT_W'(probe_ff));
                  res_write_value = probe_pattern;
                  cnt_in          = '0;
                  sub_in          = 2'd2;
               end else begin
                  // read back all positions
                  is_read         = 1'b1;
                  res_mem_address = pos_addr(cnt_ff);
                  r_exp    = (cnt_ff == CNT_W'(probe_ff)) ? probe_pattern : background_pattern;
                  r_lights = (probe_ff == LAST_PRB) ? sts_pkg::ZERO_LIGHTS
                                                    : sts_pkg::AMASK_W'(pos_addr(CNT_W'(probe_ff)));
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (cnt_ff == LAST_POS) begin
                     cnt_in   = '0;
                     sub_in   = 2'd0;
                     probe_in = probe_ff + PRB_W'(1);
                     if (probe_ff == LAST_PRB) begin
                        part_in  = PS_FILL;
                        probe_in = '0;
                     end
                  end
               end
            end
            PS_FILL: begin
               res_test_part   = sts_pkg::TP_FILL;
               res_command     = sts_pkg::CMD_WRITE;
               res_mem_address = lin_addr;
               res_write_value = inc[sts_pkg::DATA_W-1:0];
               if (at_top) begin
                  part_in = PS_CHECK1;
                  cnt_in  = '0;
                  sub_in  = 2'd0;
               end else begin
                  cnt_in = CNT_W'(lin_addr) + CNT_W'(1);
               end
            end
            PS_CHECK1: begin
               res_test_part   = sts_pkg::TP_CHECK1;
               res_mem_address = lin_addr;
               if (sub_ff == 2'd0) begin
                  is_read = 1'b1;
                  r_exp   = inc[sts_pkg::DATA_W-1:0];
                  sub_in  = 2'd1;
               end else begin
                  res_command     = sts_pkg::CMD_WRITE;
                  res_write_value = ~inc[sts_pkg::DATA_W-1:0];
                  sub_in          = 2'd0;
                  if (at_top) begin
                     part_in = PS_CHECK2;
                     cnt_in  = '0;
                  end else begin
                     cnt_in = CNT_W'(lin_addr) + CNT_W'(1);
                  end
               end
            end
            PS_CHECK2: begin
               res_test_part   = sts_pkg::TP_CHECK2;
               res_mem_address = lin_addr;
               is_read         = 1'b1;
               r_exp           = ~inc[sts_pkg::DATA_W-1:0];
               if (at_top) begin
                  part_in = PS_DONE;
                  cnt_in  = '0;
               end else begin
                  cnt_in = CNT_W'(lin_addr) + CNT_W'(1);
               end
            end
            default: begin
               part_in       = PS_DONE;
               res_command   = sts_pkg::CMD_DONE;
               res_test_part = sts_pkg::TP_CHECK2;
            end
         endcase
         // a read leaves its expectation for the next step
         if (is_read) begin
            res_command    = sts_pkg::CMD_READ;
            pend_in        = 1'b1;
            pend_exp_in    = r_exp;
            pend_addr_in   = res_mem_address;
            pend_data_in   = (part_ff == PS_DATA);
            pend_abus_in   = (part_ff == PS_ADDR);
            pend_lights_in = r_lights;
         end
      end
      res_data_bus_fails    = dmask_in;
      res_address_bus_fails = amask_in;
   end

   // State and pending-read registers
   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff        <= PS_DATA;
         cnt_ff         <= '0;
         probe_ff       <= '0;
         sub_ff         <= '0;
         pend_ff        <= 1'b0;
         pend_data_ff   <= 1'b0;
         pend_abus_ff   <= 1'b0;
         pend_exp_ff    <= '0;
         pend_addr_ff   <= '0;
         pend_lights_ff <= '0;
         dmask_ff       <= '0;
         amask_ff       <= '0;
      end else if (fire) begin
         part_ff        <= part_in;
         cnt_ff         <= cnt_in;
         probe_ff       <= probe_in;
         sub_ff         <= sub_in;
         pend_ff        <= pend_in;
         pend_data_ff   <= pend_data_in;
         pend_abus_ff   <= pend_abus_in;
         pend_exp_ff    <= pend_exp_in;
         pend_addr_ff   <= pend_addr_in;
         pend_lights_ff <= pend_lights_in;
         dmask_ff       <= dmask_in;
         amask_ff       <= amask_in;
      end
   end

   // restart leaves no read pending and the data bus part ahead
   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && !mode |=> part_ff == PS_DATA && !pend_ff && dmask_ff == '0 && amask_ff == '0)
      else $error("restart did not clear the test state");

   // every issued read is marked pending for the next step
   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      fire && mode && res_command == sts_pkg::CMD_READ |=> pend_ff)
      else $error("issued read not marked pending");

   // a mismatch needs a read to check
   a_mismatch_src: assert property (@(posedge clock) disable iff (reset)
      res_mismatch |-> pend_ff && mode)
      else $error("mismatch without a pending read");

   // fail masks only gain bits while the test advances
   a_mask_grows: assert property (@(posedge clock) disable iff (reset)
      fire && mode |=> (dmask_ff & $past(dmask_ff)) == $past(dmask_ff)
                       && (amask_ff & $past(amask_ff)) == $past(amask_ff))
      else $error("fail mask lost a bit");

endmodule
